### hdl/gtw_pkg.sv
// Shared types, constants and the glyph table of the glyph text writer.
package gtw_pkg;

	localparam int ROW_BITS_DEF = 12;
	localparam int GLYPH_LINES  = 16;
	localparam int LINE_W       = $clog2(GLYPH_LINES);
	localparam int COL_W        = 13;
	localparam int GLYPH_COUNT  = 95;
	localparam int GLYPH_W      = $clog2(GLYPH_COUNT);
	localparam int LB_W         = 18;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W    = 3;

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [7:0]  FIRST_GLYPH  = 8'd32;
	localparam logic [7:0]  LAST_GLYPH   = 8'd126;
	localparam logic [31:0] UNCACHED_BIT = 32'h8000_0000;
	localparam logic [1:0]  DEPTH_16BPP  = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN = 3'd0,
		REG_WIDTH  = 3'd1,
		REG_DEPTH  = 3'd2,
		REG_INK    = 3'd3,
		REG_PAPER  = 3'd4
	} gtw_reg_t;

	typedef struct packed {
		logic [31:0] frame_origin;
		logic [15:0] width_pixels;
		logic [1:0]  depth_select;
		logic [31:0] ink_color;
		logic [31:0] paper_color;
	} gtw_cfg_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [31:0]        base;
	} gtw_entry_t;

	// Each entry holds sixteen line bytes, the top line in the low byte.
	localparam logic [127:0] GLYPH_ROM [GLYPH_COUNT] = '{
		128'h00000000_00000000_00000000_00000000,
		128'h00001010_00001010_10101010_10101010,
		128'h00000000_00000000_00002424_24242424,
		128'h00002424_24247E7E_24247E7E_24242424,
		128'h00001010_78781414_38385050_3C3C1010,
		128'h00004646_26261010_08086464_62620000,
		128'h00003A3A_44444A4A_30304848_48483030,
		128'h00000000_00000000_00001010_10101010,
		128'h00001010_20204040_40404040_20201010,
		128'h00001010_08080404_04040404_08081010,
		128'h00001010_54543838_10103838_54541010,
		128'h00000000_10101010_7C7C1010_10100000,
		128'h00001010_08080808_00000000_00000000,
		128'h00000000_00000000_7E7E0000_00000000,
		128'h00001010_00000000_00000000_00000000,
		128'h00004040_20201010_08080404_02020000,
		128'h00003C3C_42426262_5A5A4646_42423C3C,
		128'h00001C1C_08080808_08080808_18180808,
		128'h00007E7E_40402020_1C1C0202_42423C3C,
		128'h00003C3C_42420202_1C1C0404_02027E7E,
		128'h00000404_04047E7E_24241414_0C0C0404,
		128'h00003C3C_42420202_02027C7C_40407E7E,
		128'h00003C3C_42424242_7C7C4040_20201E1E,
		128'h00001010_10101010_08080404_02027E7E,
		128'h00003C3C_42424242_3C3C4242_42423C3C,
		128'h00007878_04040202_3E3E4242_42423C3C,
		128'h00000000_00001010_00001010_00000000,
		128'h00000010_08080808_00000808_00000000,
		128'h00000404_08081010_20201010_08080404,
		128'h00000000_00007E7E_00007E7E_00000000,
		128'h00002020_10100808_04040808_10102020,
		128'h00000000_00000000_00000000_40402020,
		128'h00003E3E_40404C4C_56564A4A_42423C3C,
		128'h00004242_42427E7E_42424242_24241818,
		128'h00007C7C_42424242_7C7C4242_42427C7C,
		128'h00003C3C_42424040_40404040_42423C3C,
		128'h00007C7C_42424242_42424242_42427C7C,
		128'h00007E7E_40404040_7C7C4040_40407E7E,
		128'h00004040_40404040_7C7C4040_40407E7E,
		128'h00003E3E_4242424E_4E404040_40403E3E,
		128'h00004242_42424242_7E7E4242_42424242,
		128'h00003838_10101010_10101010_10103838,
		128'h00003C3C_42420202_02020202_02020202,
		128'h00004242_44444848_70704848_44444242,
		128'h00007E7E_40404040_40404040_40404040,
		128'h00004242_42424242_5A5A5A5A_66664242,
		128'h00004242_46464A4A_5A5A5252_62624242,
		128'h00003C3C_42424242_42424242_42423C3C,
		128'h00004040_40404040_7C7C4242_42427C7C,
		128'h00003A3A_44444A4A_42424242_42423C3C,
		128'h00004242_44444848_7C7C4242_42427C7C,
		128'h00003C3C_42420202_3C3C4040_42423C3C,
		128'h00001010_10101010_10101010_10107C7C,
		128'h00003C3C_42424242_42424242_42424242,
		128'h00001818_24244242_42424242_42424242,
		128'h00004242_66665A5A_5A5A4242_42424242,
		128'h00004242_42422424_18182424_42424242,
		128'h00001010_10101010_10102828_44444444,
		128'h00007E7E_40402020_18180404_02027E7E,
		128'h00007E7E_60606060_60606060_60607E7E,
		128'h00000202_04040808_10102020_40400000,
		128'h00007E7E_06060606_06060606_06067E7E,
		128'h00000000_00004444_28281010_00000000,
		128'h00007E7E_00000000_00000000_00000000,
		128'h00000000_00000000_00000808_10102020,
		128'h00003E3E_42423E3E_02023C3C_00000000,
		128'h00007C7C_42424242_42427C7C_40404040,
		128'h00003E3E_40404040_40403E3E_00000000,
		128'h00003E3E_42424242_42423E3E_02020202,
		128'h00003E3E_40407E7E_42423C3C_00000000,
		128'h00002020_20202020_7C7C2020_22221C1C,
		128'h3C3C0202_3E3E4242_42423C3C_00000000,
		128'h00004242_42424242_42427C7C_40404040,
		128'h00003838_10101010_10103030_00001010,
		128'h38384444_04040404_04043C3C_00000404,
		128'h00004242_44447878_44444242_40404040,
		128'h00003838_10101010_10101010_10103030,
		128'h00004242_5A5A5A5A_5A5A6666_00000000,
		128'h00004242_42424242_42427C7C_00000000,
		128'h00003C3C_42424242_42423C3C_00000000,
		128'h40404040_7C7C4242_42427C7C_00000000,
		128'h02020202_3E3E4242_42423E3E_00000000,
		128'h00004040_40404040_60605E5E_00000000,
		128'h00007C7C_02023C3C_40403E3E_00000000,
		128'h00000C0C_12121010_10107C7C_10101010,
		128'h00003A3A_46464242_42424242_00000000,
		128'h00001818_24244242_42424242_00000000,
		128'h00006666_5A5A5A5A_42424242_00000000,
		128'h00004242_24241818_24244242_00000000,
		128'h3C3C0202_3E3E4242_42424242_00000000,
		128'h00007E7E_20201818_04047E7E_00000000,
		128'h00000E0E_18181818_70701818_18180E0E,
		128'h00001010_10101010_10101010_10101010,
		128'h00007070_18181818_0E0E1818_18187070,
		128'h00000000_00004848_54542424_00000000
	};

	function automatic logic is_16bpp(input logic [1:0] depth_select);
		return depth_select == DEPTH_16BPP;
	endfunction

	// Bytes in one framebuffer line.
	function automatic logic [LB_W-1:0] line_bytes(input gtw_cfg_t cfg);
		if (is_16bpp(cfg.depth_select)) begin
			return {1'b0, cfg.width_pixels, 1'b0};
		end
		return {cfg.width_pixels, 2'b00};
	endfunction

endpackage

### hdl/gtw_front.sv
// Front end: takes characters, moves the cursor and computes each glyph's base address.
module gtw_front #(
	parameter int ROW_BITS = gtw_pkg::ROW_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gtw_pkg::gtw_cfg_t               cfg,
	input  logic                            char_valid,
	output logic                            char_stall,
	input  logic [7:0]                      char_code,
	input  logic [gtw_pkg::QCNT_W-1:0]      queue_count,
	output logic                            push,
	output gtw_pkg::gtw_entry_t             push_entry
);

	localparam int PROD_W = ROW_BITS + gtw_pkg::LB_W;

	logic [ROW_BITS-1:0]           row_q;
	logic [gtw_pkg::COL_W-1:0]     col_q;
	logic [gtw_pkg::COL_W-1:0]     col_inc;
	logic                          accept;
	logic                          is_newline;
	logic [gtw_pkg::GLYPH_W-1:0]   glyph_idx;
	logic [7:0]                    code_off;
	logic [gtw_pkg::QCNT_W:0]      pending;

	logic                          v_s1;
	logic [gtw_pkg::GLYPH_W-1:0]   glyph_s1;
	logic [ROW_BITS-1:0]           row_s1;
	logic [gtw_pkg::COL_W-1:0]     col_s1;

	logic                          v_s2;
	logic [gtw_pkg::GLYPH_W-1:0]   glyph_s2;
	logic [PROD_W-1:0]             prod_s2;
	logic [gtw_pkg::LB_W-1:0]      colofs_s2;
	logic [31:0]                   prod_wide;

	// Every transaction in flight already holds a queue slot.
	assign pending = {1'b0, queue_count} + (gtw_pkg::QCNT_W + 1)'(v_s1)
		+ (gtw_pkg::QCNT_W + 1)'(v_s2);
	assign char_stall = pending >= (gtw_pkg::QCNT_W + 1)'(gtw_pkg::QUEUE_DEPTH);
	assign accept = char_valid && !char_stall;

	assign is_newline = char_code == gtw_pkg::NEWLINE_CODE;
	assign code_off = char_code - gtw_pkg::FIRST_GLYPH;
	assign glyph_idx = (char_code >= gtw_pkg::FIRST_GLYPH && char_code <= gtw_pkg::LAST_GLYPH)
		? code_off[gtw_pkg::GLYPH_W-1:0] : '0;
	assign col_inc = col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (is_newline || col_inc >= cfg.width_pixels[15:3]) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept && !is_newline;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		glyph_s1 <= glyph_idx;
		row_s1 <= row_q;
		col_s1 <= col_q;
		glyph_s2 <= glyph_s1;
		prod_s2 <= PROD_W'(row_s1) * PROD_W'(gtw_pkg::line_bytes(cfg));
		if (gtw_pkg::is_16bpp(cfg.depth_select)) begin
			colofs_s2 <= {1'b0, col_s1, 4'b0};
		end else begin
			colofs_s2 <= {col_s1, 5'b0};
		end
	end

	assign prod_wide = 32'({prod_s2, 4'd0});
	assign push = v_s2;
	assign push_entry.glyph = glyph_s2;
	assign push_entry.base = (cfg.frame_origin | gtw_pkg::UNCACHED_BIT) + prod_wide
		+ {14'd0, colofs_s2};

endmodule

### hdl/gtw_queue.sv
// Short queue of pending glyphs between the front end and the write generator.
module gtw_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  gtw_pkg::gtw_entry_t         push_entry,
	input  logic                        pop,
	output gtw_pkg::gtw_entry_t         head,
	output logic [gtw_pkg::QCNT_W-1:0]  count
);

	localparam int PTR_W = $clog2(gtw_pkg::QUEUE_DEPTH);

	gtw_pkg::gtw_entry_t         entries_q [gtw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [gtw_pkg::QCNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head = entries_q[rd_ptr_q];
	assign count = count_q;

endmodule

### hdl/gtw_back.sv
// Back end: walks a glyph line by line and emits the packed framebuffer writes.
module gtw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gtw_pkg::gtw_cfg_t           cfg,
	input  gtw_pkg::gtw_entry_t         head,
	input  logic [gtw_pkg::QCNT_W-1:0]  queue_count,
	output logic                        pop,
	output logic                        write_valid,
	input  logic                        write_stall,
	output logic [31:0]                 write_address,
	output logic [63:0]                 write_data,
	output logic                        last_write
);

	localparam logic [gtw_pkg::LINE_W-1:0] LAST_LINE = gtw_pkg::LINE_W'(gtw_pkg::GLYPH_LINES - 1);

	logic                         busy_q;
	logic [127:0]                 glyph_q;
	logic [gtw_pkg::LINE_W-1:0]   line_q;
	logic [1:0]                   chunk_q;
	logic [31:0]                  line_addr_q;
	logic                         wv_q;

	logic                         mode16;
	logic [1:0]                   last_chunk;
	logic                         adv;
	logic                         issue;
	logic                         is_last;
	logic                         finish;
	logic                         start;
	logic [7:0]                   line_byte;
	logic [63:0]                  pixels;
	logic [2:0]                   px;

	assign mode16 = gtw_pkg::is_16bpp(cfg.depth_select);
	assign last_chunk = mode16 ? 2'd1 : 2'd3;
	assign adv = !wv_q || !write_stall;
	assign issue = busy_q && adv;
	assign is_last = line_q == LAST_LINE && chunk_q == last_chunk;
	assign finish = issue && is_last;
	assign start = (!busy_q || finish) && queue_count != '0;
	assign pop = start;
	assign line_byte = glyph_q[{line_q, 3'b000} +: 8];

	always_comb begin
		pixels = '0;
		px = '0;
		if (mode16) begin
			for (int q = 0; q < 4; q++) begin
				px = {chunk_q[0], 2'(q)};
				pixels[63 - 16 * q -: 16] = line_byte[3'd7 - px] ? cfg.ink_color[15:0]
					: cfg.paper_color[15:0];
			end
		end else begin
			for (int q = 0; q < 2; q++) begin
				px = {chunk_q, 1'(q)};
				pixels[63 - 32 * q -: 32] = line_byte[3'd7 - px] ? cfg.ink_color
					: cfg.paper_color;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wv_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				wv_q <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			glyph_q <= gtw_pkg::GLYPH_ROM[head.glyph];
			line_q <= '0;
			chunk_q <= '0;
			line_addr_q <= head.base;
		end else if (issue) begin
			if (chunk_q == last_chunk) begin
				chunk_q <= '0;
				line_q <= line_q + 1'b1;
				line_addr_q <= line_addr_q + {14'd0, gtw_pkg::line_bytes(cfg)};
			end else begin
				chunk_q <= chunk_q + 1'b1;
			end
		end
		if (issue) begin
			write_address <= line_addr_q + {27'd0, chunk_q, 3'b000};
			write_data <= pixels;
			last_write <= is_last;
		end
	end

	assign write_valid = wv_q;

endmodule

### hdl/framebuffer_glyph_text_writer_unit.sv
// Top level of the 8x16 glyph text writer with its configuration registers.
//
// Each character transaction either moves the text cursor to the next row
// (newline, no writes) or draws one 8x16 glyph as 8-byte framebuffer writes:
// 32 writes at 16bpp and 64 at 32bpp, one write per clock from the write
// generator while write_stall is low; back-to-back glyphs follow without a
// gap. A glyph character passes the front end's pipeline registers and waits in
// a four-entry queue; characters are taken while the queue has room for them and
// for those still in the front end, and a newline only moves the cursor.
// Configuration must be written while no glyph is pending.
module framebuffer_glyph_text_writer_unit #(
	parameter int ROW_BITS = gtw_pkg::ROW_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gtw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             char_valid,
	output logic                             char_stall,
	input  logic [7:0]                       char_code,
	output logic                             write_valid,
	input  logic                             write_stall,
	output logic [31:0]                      write_address,
	output logic [63:0]                      write_data,
	output logic                             last_write
);

	gtw_pkg::gtw_cfg_t           cfg_q;
	gtw_pkg::gtw_entry_t         push_entry;
	gtw_pkg::gtw_entry_t         head;
	logic                        push;
	logic                        pop;
	logic [gtw_pkg::QCNT_W-1:0]  queue_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_origin <= '0;
			cfg_q.width_pixels <= 16'd320;
			cfg_q.depth_select <= gtw_pkg::DEPTH_16BPP;
			cfg_q.ink_color <= 32'hFFFF_FFFF;
			cfg_q.paper_color <= '0;
		end else if (cfg_we) begin
			unique case (gtw_pkg::gtw_reg_t'(cfg_index))
				gtw_pkg::REG_ORIGIN: cfg_q.frame_origin <= cfg_data;
				gtw_pkg::REG_WIDTH:  cfg_q.width_pixels <= cfg_data[15:0];
				gtw_pkg::REG_DEPTH:  cfg_q.depth_select <= cfg_data[1:0];
				gtw_pkg::REG_INK:    cfg_q.ink_color <= cfg_data;
				gtw_pkg::REG_PAPER:  cfg_q.paper_color <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gtw_front #(
		.ROW_BITS(ROW_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.queue_count (queue_count),
		.push        (push),
		.push_entry  (push_entry)
	);

	gtw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.count      (queue_count)
	);

	gtw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.queue_count   (queue_count),
		.pop           (pop),
		.write_valid   (write_valid),
		.write_stall   (write_stall),
		.write_address (write_address),
		.write_data    (write_data),
		.last_write    (last_write)
	);

	// The queue is never pushed while full unless it is popped in the same cycle.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> queue_count < gtw_pkg::QCNT_W'(gtw_pkg::QUEUE_DEPTH))
		else $error("glyph queue overflow");

	// A glyph's writes come out without gaps once the first one is taken.
	a_glyph_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && !write_stall && !last_write |=> write_valid)
		else $error("gap inside a glyph's write transactions");

	// A printable or repaired character reaches the queue via the v_s1 and v_s2 stages.
	a_char_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && char_code != gtw_pkg::NEWLINE_CODE |=> ##1 push)
		else $error("character transaction lost before the queue");

endmodule

### bench/testbench.sv
// Self-checking testbench for the 8x16 glyph text writer: a random-stall driver and checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_W = gtw_pkg::ROW_BITS_DEF;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_PHASES = 6;
	localparam int CHARS_PER_PHASE = 60;
	localparam int PRINT_CAP = 100;
	localparam logic [gtw_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [gtw_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

	// Four words per glyph, each word holds four lines with the top line in the low byte.
	localparam logic [31:0] FONT_WORDS [gtw_pkg::GLYPH_COUNT*4] = '{
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h10101010, 32'h10101010, 32'h00001010, 32'h00001010,
		32'h24242424, 32'h00002424, 32'h00000000, 32'h00000000,
		32'h24242424, 32'h24247E7E, 32'h24247E7E, 32'h00002424,
		32'h3C3C1010, 32'h38385050, 32'h78781414, 32'h00001010,
		32'h62620000, 32'h08086464, 32'h26261010, 32'h00004646,
		32'h48483030, 32'h30304848, 32'h44444A4A, 32'h00003A3A,
		32'h10101010, 32'h00001010, 32'h00000000, 32'h00000000,
		32'h20201010, 32'h40404040, 32'h20204040, 32'h00001010,
		32'h08081010, 32'h04040404, 32'h08080404, 32'h00001010,
		32'h54541010, 32'h10103838, 32'h54543838, 32'h00001010,
		32'h10100000, 32'h7C7C1010, 32'h10101010, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h08080808, 32'h00001010,
		32'h00000000, 32'h7E7E0000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00001010,
		32'h02020000, 32'h08080404, 32'h20201010, 32'h00004040,
		32'h42423C3C, 32'h5A5A4646, 32'h42426262, 32'h00003C3C,
		32'h18180808, 32'h08080808, 32'h08080808, 32'h00001C1C,
		32'h42423C3C, 32'h1C1C0202, 32'h40402020, 32'h00007E7E,
		32'h02027E7E, 32'h1C1C0404, 32'h42420202, 32'h00003C3C,
		32'h0C0C0404, 32'h24241414, 32'h04047E7E, 32'h00000404,
		32'h40407E7E, 32'h02027C7C, 32'h42420202, 32'h00003C3C,
		32'h20201E1E, 32'h7C7C4040, 32'h42424242, 32'h00003C3C,
		32'h02027E7E, 32'h08080404, 32'h10101010, 32'h00001010,
		32'h42423C3C, 32'h3C3C4242, 32'h42424242, 32'h00003C3C,
		32'h42423C3C, 32'h3E3E4242, 32'h04040202, 32'h00007878,
		32'h00000000, 32'h00001010, 32'h00001010, 32'h00000000,
		32'h00000000, 32'h00000808, 32'h08080808, 32'h00000010,
		32'h08080404, 32'h20201010, 32'h08081010, 32'h00000404,
		32'h00000000, 32'h00007E7E, 32'h00007E7E, 32'h00000000,
		32'h10102020, 32'h04040808, 32'h10100808, 32'h00002020,
		32'h40402020, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h42423C3C, 32'h56564A4A, 32'h40404C4C, 32'h00003E3E,
		32'h24241818, 32'h42424242, 32'h42427E7E, 32'h00004242,
		32'h42427C7C, 32'h7C7C4242, 32'h42424242, 32'h00007C7C,
		32'h42423C3C, 32'h40404040, 32'h42424040, 32'h00003C3C,
		32'h42427C7C, 32'h42424242, 32'h42424242, 32'h00007C7C,
		32'h40407E7E, 32'h7C7C4040, 32'h40404040, 32'h00007E7E,
		32'h40407E7E, 32'h7C7C4040, 32'h40404040, 32'h00004040,
		32'h40403E3E, 32'h4E404040, 32'h4242424E, 32'h00003E3E,
		32'h42424242, 32'h7E7E4242, 32'h42424242, 32'h00004242,
		32'h10103838, 32'h10101010, 32'h10101010, 32'h00003838,
		32'h02020202, 32'h02020202, 32'h42420202, 32'h00003C3C,
		32'h44444242, 32'h70704848, 32'h44444848, 32'h00004242,
		32'h40404040, 32'h40404040, 32'h40404040, 32'h00007E7E,
		32'h66664242, 32'h5A5A5A5A, 32'h42424242, 32'h00004242,
		32'h62624242, 32'h5A5A5252, 32'h46464A4A, 32'h00004242,
		32'h42423C3C, 32'h42424242, 32'h42424242, 32'h00003C3C,
		32'h42427C7C, 32'h7C7C4242, 32'h40404040, 32'h00004040,
		32'h42423C3C, 32'h42424242, 32'h44444A4A, 32'h00003A3A,
		32'h42427C7C, 32'h7C7C4242, 32'h44444848, 32'h00004242,
		32'h42423C3C, 32'h3C3C4040, 32'h42420202, 32'h00003C3C,
		32'h10107C7C, 32'h10101010, 32'h10101010, 32'h00001010,
		32'h42424242, 32'h42424242, 32'h42424242, 32'h00003C3C,
		32'h42424242, 32'h42424242, 32'h24244242, 32'h00001818,
		32'h42424242, 32'h5A5A4242, 32'h66665A5A, 32'h00004242,
		32'h42424242, 32'h18182424, 32'h42422424, 32'h00004242,
		32'h44444444, 32'h10102828, 32'h10101010, 32'h00001010,
		32'h02027E7E, 32'h18180404, 32'h40402020, 32'h00007E7E,
		32'h60607E7E, 32'h60606060, 32'h60606060, 32'h00007E7E,
		32'h40400000, 32'h10102020, 32'h04040808, 32'h00000202,
		32'h06067E7E, 32'h06060606, 32'h06060606, 32'h00007E7E,
		32'h00000000, 32'h28281010, 32'h00004444, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00007E7E,
		32'h10102020, 32'h00000808, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h02023C3C, 32'h42423E3E, 32'h00003E3E,
		32'h40404040, 32'h42427C7C, 32'h42424242, 32'h00007C7C,
		32'h00000000, 32'h40403E3E, 32'h40404040, 32'h00003E3E,
		32'h02020202, 32'h42423E3E, 32'h42424242, 32'h00003E3E,
		32'h00000000, 32'h42423C3C, 32'h40407E7E, 32'h00003E3E,
		32'h22221C1C, 32'h7C7C2020, 32'h20202020, 32'h00002020,
		32'h00000000, 32'h42423C3C, 32'h3E3E4242, 32'h3C3C0202,
		32'h40404040, 32'h42427C7C, 32'h42424242, 32'h00004242,
		32'h00001010, 32'h10103030, 32'h10101010, 32'h00003838,
		32'h00000404, 32'h04043C3C, 32'h04040404, 32'h38384444,
		32'h40404040, 32'h44444242, 32'h44447878, 32'h00004242,
		32'h10103030, 32'h10101010, 32'h10101010, 32'h00003838,
		32'h00000000, 32'h5A5A6666, 32'h5A5A5A5A, 32'h00004242,
		32'h00000000, 32'h42427C7C, 32'h42424242, 32'h00004242,
		32'h00000000, 32'h42423C3C, 32'h42424242, 32'h00003C3C,
		32'h00000000, 32'h42427C7C, 32'h7C7C4242, 32'h40404040,
		32'h00000000, 32'h42423E3E, 32'h3E3E4242, 32'h02020202,
		32'h00000000, 32'h60605E5E, 32'h40404040, 32'h00004040,
		32'h00000000, 32'h40403E3E, 32'h02023C3C, 32'h00007C7C,
		32'h10101010, 32'h10107C7C, 32'h12121010, 32'h00000C0C,
		32'h00000000, 32'h42424242, 32'h46464242, 32'h00003A3A,
		32'h00000000, 32'h42424242, 32'h24244242, 32'h00001818,
		32'h00000000, 32'h42424242, 32'h5A5A5A5A, 32'h00006666,
		32'h00000000, 32'h24244242, 32'h24241818, 32'h00004242,
		32'h00000000, 32'h42424242, 32'h3E3E4242, 32'h3C3C0202,
		32'h00000000, 32'h04047E7E, 32'h20201818, 32'h00007E7E,
		32'h18180E0E, 32'h70701818, 32'h18181818, 32'h00000E0E,
		32'h10101010, 32'h10101010, 32'h10101010, 32'h00001010,
		32'h18187070, 32'h0E0E1818, 32'h18181818, 32'h00007070,
		32'h00000000, 32'h54542424, 32'h00004848, 32'h00000000
	};

	typedef struct packed {
		logic [31:0] addr;
		logic [63:0] data;
		logic        is_last;
	} fb_write_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [gtw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                   cfg_data = '0;
	logic                          char_valid = 1'b0;
	logic                          char_stall;
	logic [7:0]                    char_code = '0;
	logic                          write_valid;
	logic                          write_stall = 1'b0;
	logic [31:0]                   write_address;
	logic [63:0]                   write_data;
	logic                          last_write;

	logic [31:0]               shadow_origin = 32'h0000_0000;
	logic [15:0]               shadow_width = 16'd320;
	logic [1:0]                fb_depth = gtw_pkg::DEPTH_16BPP;
	logic [31:0]               fb_ink = 32'hFFFF_FFFF;
	logic [31:0]               fb_paper = 32'h0000_0000;
	logic [gtw_pkg::COL_W-1:0] text_col = '0;
	logic [ROW_W-1:0]          text_row = '0;

	fb_write_t  expected_writes[$];
	logic [7:0] char_backlog[$];
	int         chars_queued = 0;
	int         chars_taken = 0;
	int         mismatches = 0;
	int         idle_pct = 17;
	int         stall_pct = 17;
	int         cycle_count = 0;

	framebuffer_glyph_text_writer_unit #(.ROW_BITS(ROW_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.write_valid(write_valid),
		.write_stall(write_stall),
		.write_address(write_address),
		.write_data(write_data),
		.last_write(last_write)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// Updates the cursor and queues every framebuffer write that one character causes.
	task automatic predict_char(input logic [7:0] c);
		logic [6:0]                glyph;
		logic                      wide;
		logic [31:0]               lb;
		logic [31:0]               cb;
		logic [31:0]               base;
		logic [31:0]               word;
		logic [31:0]               color;
		logic [7:0]                bits;
		logic [63:0]               data;
		logic [gtw_pkg::COL_W-1:0] next_col;
		int                        chunks;
		int                        per;
		fb_write_t                 w;
		if (c == gtw_pkg::NEWLINE_CODE) begin
			text_col = '0;
			text_row = text_row + 1'b1;
			return;
		end
		glyph = (c >= gtw_pkg::FIRST_GLYPH && c <= gtw_pkg::LAST_GLYPH)
			? 7'(c - gtw_pkg::FIRST_GLYPH) : 7'd0;
		wide = (fb_depth != gtw_pkg::DEPTH_16BPP);
		lb = wide ? {14'd0, shadow_width, 2'b00} : {15'd0, shadow_width, 1'b0};
		cb = wide ? 32'd32 : 32'd16;
		chunks = wide ? 4 : 2;
		per = 8 / chunks;
		base = (shadow_origin | gtw_pkg::UNCACHED_BIT)
			+ lb * (32'(text_row) * 32'(gtw_pkg::GLYPH_LINES)) + 32'(text_col) * cb;
		for (int line = 0; line < gtw_pkg::GLYPH_LINES; line++) begin
			word = FONT_WORDS[glyph * 4 + line / 4];
			bits = word[8 * (line % 4) +: 8];
			for (int k = 0; k < chunks; k++) begin
				data = '0;
				for (int q = 0; q < per; q++) begin
					color = bits[7 - (k * per + q)] ? fb_ink : fb_paper;
					if (wide) begin
						data[63 - 32 * q -: 32] = color;
					end else begin
						data[63 - 16 * q -: 16] = color[15:0];
					end
				end
				w.addr = base + 32'(line) * lb + 32'(k) * 32'd8;
				w.data = data;
				w.is_last = (line == gtw_pkg::GLYPH_LINES - 1) && (k == chunks - 1);
				expected_writes.push_back(w);
			end
		end
		next_col = text_col + 1'b1;
		if (32'(next_col) >= 32'(shadow_width >> 3)) begin
			text_col = '0;
			text_row = text_row + 1'b1;
		end else begin
			text_col = next_col;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_code <= '0;
		end else begin
			if (char_valid && !char_stall) begin
				predict_char(char_code);
				chars_taken++;
			end
			if (!char_valid || !char_stall) begin
				if (char_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					char_valid <= 1'b1;
					char_code <= char_backlog.pop_front();
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		fb_write_t want;
		if (!arst_n) begin
			write_stall <= 1'b0;
		end else begin
			if (write_valid && !write_stall) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write to %h", write_address));
				end else begin
					want = expected_writes.pop_front();
					if (write_address !== want.addr) begin
						report_mismatch($sformatf("address %h, want %h",
							write_address, want.addr));
					end
					if (write_data !== want.data) begin
						report_mismatch($sformatf("data %h at %h, want %h",
							write_data, want.addr, want.data));
					end
					if (last_write !== want.is_last) begin
						report_mismatch($sformatf("last flag %b at %h, want %b",
							last_write, want.addr, want.is_last));
					end
				end
			end
			write_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_char(input logic [7:0] c);
		char_backlog.push_back(c);
		chars_queued++;
	endtask

	task automatic write_reg(input logic [gtw_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			gtw_pkg::REG_ORIGIN: shadow_origin = value;
			gtw_pkg::REG_WIDTH: shadow_width = value[15:0];
			gtw_pkg::REG_DEPTH: fb_depth = value[1:0];
			gtw_pkg::REG_INK: fb_ink = value;
			gtw_pkg::REG_PAPER: fb_paper = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Holds off until every character is taken, every write has arrived and the
	// block has had time to retire a trailing newline.
	task automatic wait_idle();
		while (chars_taken != chars_queued) @(posedge clk);
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_setup();
		logic [15:0] w;
		case ($urandom_range(3))
			0: w = 16'($urandom_range(7));
			1: w = 16'($urandom_range(8, 127));
			2: w = 16'($urandom_range(128, 2047));
			default: w = 16'($urandom);
		endcase
		write_reg(gtw_pkg::REG_ORIGIN, $urandom);
		write_reg(gtw_pkg::REG_WIDTH, {16'($urandom), w});
		write_reg(gtw_pkg::REG_DEPTH, {30'($urandom), 2'($urandom)});
		write_reg(gtw_pkg::REG_INK, $urandom);
		write_reg(gtw_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
			$urandom);
		write_reg(gtw_pkg::REG_PAPER, $urandom);
	endtask

	function automatic logic [7:0] random_char();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return 8'($urandom_range(gtw_pkg::FIRST_GLYPH, gtw_pkg::LAST_GLYPH));
		end else if (r < 82) begin
			return gtw_pkg::NEWLINE_CODE;
		end
		return 8'($urandom_range(255));
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_char(8'h20);
		queue_char(8'h41);
		queue_char(8'h7E);
		queue_char(8'h7F);
		queue_char(8'h00);
		queue_char(8'hFF);
		queue_char(gtw_pkg::NEWLINE_CODE);
		queue_char(8'h67);
		queue_char(8'h1F);
		wait_idle();

		write_reg(gtw_pkg::REG_ORIGIN, 32'h7FFF_FFF8);
		write_reg(gtw_pkg::REG_WIDTH, 32'd7);
		write_reg(gtw_pkg::REG_DEPTH, 32'd2);
		write_reg(gtw_pkg::REG_INK, 32'h1234_5678);
		write_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);
		write_reg(gtw_pkg::REG_PAPER, 32'h9ABC_DEF0);
		queue_char(8'h21);
		queue_char(8'h5F);
		queue_char(gtw_pkg::NEWLINE_CODE);
		queue_char(8'h80);
		wait_idle();

		write_reg(gtw_pkg::REG_ORIGIN, 32'hFFFF_FFF0);
		write_reg(gtw_pkg::REG_WIDTH, 32'hA5A5_FFFF);
		write_reg(gtw_pkg::REG_DEPTH, 32'hFFFF_FFFC);
		write_reg(gtw_pkg::REG_INK, 32'h0000_0000);
		write_reg(gtw_pkg::REG_PAPER, 32'hFFFF_FFFF);
		queue_char(8'h4D);
		queue_char(8'h23);
		queue_char(gtw_pkg::NEWLINE_CODE);
		queue_char(8'h7E);
		wait_idle();

		write_reg(gtw_pkg::REG_ORIGIN, 32'h0000_0000);
		write_reg(gtw_pkg::REG_WIDTH, 32'h0000_0000);
		write_reg(gtw_pkg::REG_DEPTH, 32'h0000_0003);
		write_reg(gtw_pkg::REG_INK, 32'h0000_FFFF);
		write_reg(gtw_pkg::REG_PAPER, 32'hFFFF_0000);
		queue_char(8'h40);
		queue_char(8'h09);
		wait_idle();

		write_reg(gtw_pkg::REG_WIDTH, 32'd16);
		write_reg(gtw_pkg::REG_DEPTH, 32'd1);
		queue_char(8'h30);
		queue_char(8'h31);
		queue_char(8'h32);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_setup();
			idle_pct = (p == 2) ? 0 : 17;
			stall_pct = (p == 2) ? 0 : 17;
			repeat (CHARS_PER_PHASE) queue_char(random_char());
			wait_idle();
		end

		while (expected_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
